[rtl/core/plt_pkg.sv]
// Package for the particle lifetime update block.
// Holds the shared constants, codes, command/status structs and fixed-point helpers.
// No dependencies.
package plt_pkg;

    // Width of a stored position coordinate (signed Q8.8 when 16).
    localparam int COORD_BITS = 16;

    // Shared multiplier operand and product widths.
    localparam int MUL_A_W = 18;
    localparam int MUL_B_W = 33;
    localparam int PROD_W  = MUL_A_W + MUL_B_W;

    // Width of the motion accumulator and of the position sum before saturation.
    localparam int ACC_W = 40;

    // Fraction divider: one quotient bit per cycle.
    localparam int DIV_STEPS = 16;
    localparam int DIV_CNT_W = $clog2(DIV_STEPS + 1);

    // Alpha scale factors in Q0.16.
    localparam logic [15:0] ALPHA_TEX   = 16'd26214;
    localparam logic [15:0] ALPHA_PLAIN = 16'd39322;

    // Alpha and size indices in the interpolation sequence, last axis in the motion.
    localparam logic [2:0] CHAN_ALPHA = 3'd3;
    localparam logic [2:0] CHAN_SIZE  = 3'd4;
    localparam logic [2:0] AXIS_LAST  = 3'd2;

    typedef enum logic [2:0] {
        REG_START_POS    = 3'd0,
        REG_VELOCITY     = 3'd1,
        REG_ACCEL        = 3'd2,
        REG_BEGIN_COLOR  = 3'd3,
        REG_END_COLOR    = 3'd4,
        REG_SIZE_RANGE   = 3'd5,
        REG_LIFETIME     = 3'd6,
        REG_TEXTURE_MODE = 3'd7
    } cfg_reg_t;

    typedef enum logic [2:0] {
        MUL_NONE,
        MUL_TT,
        MUL_VT,
        MUL_AT2,
        MUL_LERP,
        MUL_ALPHA
    } mul_op_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SPAWN,
        ST_TSQ,
        ST_VT_MUL,
        ST_AT2_MUL,
        ST_POS_WR,
        ST_DIV_WAIT,
        ST_LERP_MUL,
        ST_LERP_WR,
        ST_ALPHA_MUL,
        ST_ALPHA_WR,
        ST_FINISH
    } plt_state_t;

    typedef struct packed {
        logic       t_load;
        logic       t2_load;
        logic       acc_load;
        logic       pos_spawn;
        logic       pos_wr;
        logic       chan_wr;
        logic       alpha_wr;
        logic       finish;
        mul_op_t    mul_op;
        logic [2:0] idx;
    } plt_cmd_t;

    typedef struct packed {
        logic respawn_due;
        logic div_done;
    } plt_status_t;

    // Signed 16-bit coordinate of one axis; x is the highest field.
    function automatic logic signed [15:0] field16(input logic [47:0] word,
                                                   input logic [1:0] axis);
        logic signed [15:0] res;
        case (axis)
            2'd0:    res = word[47:32];
            2'd1:    res = word[31:16];
            default: res = word[15:0];
        endcase
        return res;
    endfunction

    localparam logic signed [ACC_W-1:0] COORD_MAX =
        {{(ACC_W - COORD_BITS + 1){1'b0}}, {(COORD_BITS - 1){1'b1}}};
    localparam logic signed [ACC_W-1:0] COORD_MIN = ~COORD_MAX;
    localparam logic signed [ACC_W-1:0] OUT_MAX = ACC_W'(32767);
    localparam logic signed [ACC_W-1:0] OUT_MIN = ~OUT_MAX;

    function automatic logic signed [COORD_BITS-1:0] sat_coord(
        input logic signed [ACC_W-1:0] x);
        logic signed [ACC_W-1:0] c;
        if (x > COORD_MAX) begin
            c = COORD_MAX;
        end else if (x < COORD_MIN) begin
            c = COORD_MIN;
        end else begin
            c = x;
        end
        return c[COORD_BITS-1:0];
    endfunction

    // Clamp a stored coordinate to the 16-bit output range.
    function automatic logic [15:0] out_coord(input logic signed [COORD_BITS-1:0] p);
        logic signed [ACC_W-1:0] x;
        logic signed [ACC_W-1:0] c;
        x = ACC_W'(p);
        if (x > OUT_MAX) begin
            c = OUT_MAX;
        end else if (x < OUT_MIN) begin
            c = OUT_MIN;
        end else begin
            c = x;
        end
        return c[15:0];
    endfunction

endpackage

[rtl/core/plt_div.sv]
// Bit-serial divider for the life fraction (remaining << 16) / lifetime.
// One quotient bit per cycle; a saturation flag forces the fraction to 1.0.
// Depends on plt_pkg.
module plt_div
    import plt_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        start,
    input  logic        sat,
    input  logic [15:0] num,
    input  logic [15:0] den,
    output logic [16:0] frac,
    output logic        done
);

    logic [DIV_CNT_W-1:0] cnt_reg;
    logic [15:0]          rem_reg;
    logic [15:0]          quo_reg;
    logic                 sat_reg;

    logic [16:0] shifted;
    logic [16:0] diff;
    logic        ge;

    assign shifted = {rem_reg, 1'b0};
    assign ge      = shifted >= {1'b0, den};
    assign diff    = shifted - {1'b0, den};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= DIV_CNT_W'(DIV_STEPS);
        end else if (start) begin
            cnt_reg <= '0;
        end else if (!done) begin
            cnt_reg <= cnt_reg + 1'b1;
        end
    end

    // The numerator is below the divisor unless saturated, so the partial
    // remainder always fits in 16 bits.
    always_ff @(posedge aclk) begin
        if (start) begin
            rem_reg <= num;
            quo_reg <= '0;
            sat_reg <= sat;
        end else if (!done) begin
            rem_reg <= ge ? diff[15:0] : shifted[15:0];
            quo_reg <= {quo_reg[14:0], ge};
        end
    end

    assign done = (cnt_reg == DIV_CNT_W'(DIV_STEPS));
    assign frac = sat_reg ? 17'h10000 : {1'b0, quo_reg};

endmodule

[rtl/core/plt_dp.sv]
// Datapath of the particle lifetime update: configuration registers, particle
// state, the shared multiplier, the fraction divider and the result register.
// Depends on plt_pkg and plt_div.
module plt_dp
    import plt_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_wr_en,
    input  logic [2:0]  cfg_index,
    input  logic [47:0] cfg_wdata,
    input  logic [15:0] time_step,
    input  plt_cmd_t    cmd,
    output plt_status_t status,
    output logic [95:0] out_data,
    output logic        out_respawned
);

    // Configuration.
    logic [47:0] start_pos_reg;
    logic [47:0] velocity_reg;
    logic [47:0] accel_reg;
    logic [31:0] begin_color_reg;
    logic [31:0] end_color_reg;
    logic [31:0] size_range_reg;
    logic [15:0] lifetime_reg;
    logic        texture_mode_reg;

    // Particle state.
    logic signed [COORD_BITS-1:0] pos_reg [3];
    logic signed [17:0]           life_reg;
    logic [7:0]                   color_reg [4];
    logic [15:0]                  size_reg;

    // Working registers.
    logic [15:0]              t_reg;
    logic [31:0]              t2_reg;
    logic                     resp_reg;
    logic signed [ACC_W-1:0]  acc_reg;
    logic signed [PROD_W-1:0] prod_reg;

    // Result register.
    logic [15:0] out_pos_reg [3];
    logic [7:0]  out_color_reg [4];
    logic [15:0] out_size_reg;
    logic        out_resp_reg;

    logic [16:0] frac;
    logic        div_done;
    logic        frac_sat;
    logic [16:0] t_round;
    logic [12:0] dq;
    logic [17:0] life_base;

    logic signed [MUL_A_W-1:0] mul_a;
    logic signed [MUL_B_W-1:0] mul_b;
    logic signed [15:0]        vel_axis;
    logic signed [15:0]        acc_axis;
    logic [15:0]               lerp_begin;
    logic [15:0]               lerp_end;
    logic [16:0]               lerp_diff;

    logic signed [ACC_W-1:0]  motion_sum;
    logic signed [ACC_W-1:0]  delta;
    logic signed [ACC_W-1:0]  pos_sum;
    logic signed [PROD_W-1:0] half_term;
    logic [PROD_W-1:0]        lerp_sum;
    logic [PROD_W-1:0]        alpha_sum;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            start_pos_reg    <= '0;
            velocity_reg     <= '0;
            accel_reg        <= '0;
            begin_color_reg  <= 32'hFFFF00FF;
            end_color_reg    <= 32'hFF0000FF;
            size_range_reg   <= 32'h02000000;
            lifetime_reg     <= 16'h0100;
            texture_mode_reg <= 1'b0;
        end else if (cfg_wr_en) begin
            case (cfg_reg_t'(cfg_index))
                REG_START_POS:    start_pos_reg    <= cfg_wdata;
                REG_VELOCITY:     velocity_reg     <= cfg_wdata;
                REG_ACCEL:        accel_reg        <= cfg_wdata;
                REG_BEGIN_COLOR:  begin_color_reg  <= cfg_wdata[31:0];
                REG_END_COLOR:    end_color_reg    <= cfg_wdata[31:0];
                REG_SIZE_RANGE:   size_range_reg   <= cfg_wdata[31:0];
                REG_LIFETIME:     lifetime_reg     <= cfg_wdata[15:0];
                REG_TEXTURE_MODE: texture_mode_reg <= cfg_wdata[0];
                default: ;
            endcase
        end
    end

    // Life is in Q8.8 while the time step is Q4.12: round it to Q8.8.
    assign t_round   = {1'b0, t_reg} + 17'd8;
    assign dq        = t_round[16:4];
    assign life_base = resp_reg ? {2'b00, lifetime_reg} : life_reg;

    assign status.respawn_due = life_reg[17] || (life_reg == '0);
    assign status.div_done    = div_done;

    assign frac_sat = (lifetime_reg == '0) || (life_reg >= $signed({2'b00, lifetime_reg}));

    plt_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (cmd.t_load),
        .sat     (frac_sat),
        .num     (life_reg[15:0]),
        .den     (lifetime_reg),
        .frac    (frac),
        .done    (div_done)
    );

    assign vel_axis = field16(velocity_reg, cmd.idx[1:0]);
    assign acc_axis = field16(accel_reg, cmd.idx[1:0]);

    always_comb begin
        case (cmd.idx)
            3'd0: begin
                lerp_begin = {8'h00, begin_color_reg[31:24]};
                lerp_end   = {8'h00, end_color_reg[31:24]};
            end
            3'd1: begin
                lerp_begin = {8'h00, begin_color_reg[23:16]};
                lerp_end   = {8'h00, end_color_reg[23:16]};
            end
            3'd2: begin
                lerp_begin = {8'h00, begin_color_reg[15:8]};
                lerp_end   = {8'h00, end_color_reg[15:8]};
            end
            3'd3: begin
                lerp_begin = {8'h00, begin_color_reg[7:0]};
                lerp_end   = {8'h00, end_color_reg[7:0]};
            end
            default: begin
                lerp_begin = size_range_reg[31:16];
                lerp_end   = size_range_reg[15:0];
            end
        endcase
    end

    assign lerp_diff = {1'b0, lerp_begin} - {1'b0, lerp_end};

    always_comb begin
        case (cmd.mul_op)
            MUL_TT: begin
                mul_a = {2'b00, t_reg};
                mul_b = {17'd0, t_reg};
            end
            MUL_VT: begin
                mul_a = MUL_A_W'(vel_axis);
                mul_b = {17'd0, t_reg};
            end
            MUL_AT2: begin
                mul_a = MUL_A_W'(acc_axis);
                mul_b = {1'b0, t2_reg};
            end
            MUL_LERP: begin
                mul_a = MUL_A_W'($signed(lerp_diff));
                mul_b = {16'd0, frac};
            end
            MUL_ALPHA: begin
                mul_a = {10'd0, color_reg[3]};
                mul_b = {17'd0, (texture_mode_reg ? ALPHA_TEX : ALPHA_PLAIN)};
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    // Motion: delta = floor((v*t + floor(a*t*t / 2^13) + 2048) / 2^12).
    assign half_term  = prod_reg >>> 13;
    assign motion_sum = acc_reg + half_term[ACC_W-1:0] + ACC_W'(2048);
    assign delta      = motion_sum >>> 12;
    assign pos_sum    = ACC_W'(pos_reg[cmd.idx[1:0]]) + delta;

    // end*(1-f) + begin*f is the same as end*2^16 + (begin-end)*f.
    assign lerp_sum  = {{(PROD_W - 32){1'b0}}, lerp_end, 16'h0000} + prod_reg
                     + PROD_W'(32768);
    assign alpha_sum = prod_reg + PROD_W'(32768);

    always_ff @(posedge aclk) begin
        if (cmd.mul_op != MUL_NONE) begin
            prod_reg <= mul_a * mul_b;
        end
        if (cmd.t_load) begin
            t_reg <= time_step;
        end
        if (cmd.t2_load) begin
            t2_reg <= prod_reg[31:0];
        end
        if (cmd.acc_load) begin
            acc_reg <= prod_reg[ACC_W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < 3; i++) begin
                pos_reg[i] <= '0;
            end
            for (int i = 0; i < 4; i++) begin
                color_reg[i] <= '0;
            end
            size_reg <= '0;
            life_reg <= '0;
            resp_reg <= 1'b0;
        end else begin
            if (cmd.t_load) begin
                resp_reg <= status.respawn_due;
            end
            if (cmd.pos_spawn) begin
                for (int i = 0; i < 3; i++) begin
                    pos_reg[i] <= sat_coord(ACC_W'(field16(start_pos_reg, 2'(i))));
                end
            end
            if (cmd.pos_wr) begin
                pos_reg[cmd.idx[1:0]] <= sat_coord(pos_sum);
            end
            if (cmd.chan_wr) begin
                if (cmd.idx == CHAN_SIZE) begin
                    size_reg <= lerp_sum[31:16];
                end else begin
                    color_reg[cmd.idx[1:0]] <= lerp_sum[23:16];
                end
            end
            if (cmd.alpha_wr) begin
                color_reg[3] <= alpha_sum[23:16];
            end
            if (cmd.finish) begin
                life_reg <= life_base - {5'd0, dq};
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.finish) begin
            for (int i = 0; i < 3; i++) begin
                out_pos_reg[i] <= out_coord(pos_reg[i]);
            end
            for (int i = 0; i < 4; i++) begin
                out_color_reg[i] <= color_reg[i];
            end
            out_size_reg <= size_reg;
            out_resp_reg <= resp_reg;
        end
    end

    assign out_data = {out_size_reg, out_color_reg[3], out_color_reg[2], out_color_reg[1],
                       out_color_reg[0], out_pos_reg[2], out_pos_reg[1], out_pos_reg[0]};
    assign out_respawned = out_resp_reg;

endmodule

[rtl/core/plt_ctrl.sv]
// Controller of the particle lifetime update: sequences the shared multiplier,
// the position updates and the interpolations, and owns both handshakes.
// Depends on plt_pkg.
module plt_ctrl
    import plt_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    output logic        m_tvalid,
    input  logic        m_tready,
    input  plt_status_t status,
    output plt_cmd_t    cmd
);

    plt_state_t state_reg;
    plt_state_t state_next;
    logic [2:0] idx_reg;
    logic [2:0] idx_next;
    logic       out_valid_reg;
    logic       out_valid_next;
    logic       accept;
    logic       out_free;

    assign s_tready = (state_reg == ST_IDLE);
    assign accept   = s_tvalid && s_tready;
    assign out_free = !out_valid_reg || m_tready;
    assign m_tvalid = out_valid_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            idx_reg       <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            idx_reg       <= idx_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    state_next = status.respawn_due ? ST_SPAWN : ST_TSQ;
                end
            end
            ST_SPAWN:     state_next = ST_FINISH;
            ST_TSQ:       state_next = ST_VT_MUL;
            ST_VT_MUL:    state_next = ST_AT2_MUL;
            ST_AT2_MUL:   state_next = ST_POS_WR;
            ST_POS_WR:    state_next = (idx_reg == AXIS_LAST) ? ST_DIV_WAIT : ST_VT_MUL;
            ST_DIV_WAIT: begin
                if (status.div_done) begin
                    state_next = ST_LERP_MUL;
                end
            end
            ST_LERP_MUL:  state_next = ST_LERP_WR;
            ST_LERP_WR: begin
                if (idx_reg == CHAN_ALPHA) begin
                    state_next = ST_ALPHA_MUL;
                end else if (idx_reg == CHAN_SIZE) begin
                    state_next = ST_FINISH;
                end else begin
                    state_next = ST_LERP_MUL;
                end
            end
            ST_ALPHA_MUL: state_next = ST_ALPHA_WR;
            ST_ALPHA_WR:  state_next = ST_LERP_MUL;
            ST_FINISH: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default:      state_next = ST_IDLE;
        endcase
    end

    // Axis index during motion, channel index during interpolation.
    always_comb begin
        idx_next = idx_reg;
        case (state_reg)
            ST_IDLE:     idx_next = '0;
            ST_POS_WR:   idx_next = (idx_reg == AXIS_LAST) ? 3'd0 : idx_reg + 3'd1;
            ST_LERP_WR: begin
                if (idx_reg != CHAN_ALPHA && idx_reg != CHAN_SIZE) begin
                    idx_next = idx_reg + 3'd1;
                end
            end
            ST_ALPHA_WR: idx_next = CHAN_SIZE;
            default:     idx_next = idx_reg;
        endcase
    end

    always_comb begin
        out_valid_next = out_valid_reg;
        if (cmd.finish) begin
            out_valid_next = 1'b1;
        end else if (m_tready) begin
            out_valid_next = 1'b0;
        end
    end

    always_comb begin
        cmd           = '0;
        cmd.mul_op    = MUL_NONE;
        cmd.idx       = idx_reg;
        cmd.t_load    = accept;
        case (state_reg)
            ST_SPAWN:     cmd.pos_spawn = 1'b1;
            ST_TSQ:       cmd.mul_op = MUL_TT;
            ST_VT_MUL: begin
                cmd.mul_op  = MUL_VT;
                cmd.t2_load = (idx_reg == 3'd0);
            end
            ST_AT2_MUL: begin
                cmd.mul_op   = MUL_AT2;
                cmd.acc_load = 1'b1;
            end
            ST_POS_WR:    cmd.pos_wr = 1'b1;
            ST_LERP_MUL:  cmd.mul_op = MUL_LERP;
            ST_LERP_WR:   cmd.chan_wr = 1'b1;
            ST_ALPHA_MUL: cmd.mul_op = MUL_ALPHA;
            ST_ALPHA_WR:  cmd.alpha_wr = 1'b1;
            ST_FINISH:    cmd.finish = out_free;
            default: ;
        endcase
    end

    a_accept_leaves_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        accept |=> state_reg != ST_IDLE)
        else $error("controller stayed idle after taking a beat");

    a_finish_only_when_free: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.finish |-> (!out_valid_reg || m_tready))
        else $error("result register overwritten while its beat is pending");

    a_lerp_after_div: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_LERP_MUL && $past(state_reg) == ST_DIV_WAIT)
        |-> $past(status.div_done))
        else $error("interpolation started before the fraction was ready");

    a_idx_range: assert property (@(posedge aclk) disable iff (!aresetn)
        idx_reg <= CHAN_SIZE)
        else $error("sequence index out of range");

    a_valid_from_finish: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(out_valid_reg) |-> $past(state_reg) == ST_FINISH)
        else $error("result beat raised outside the finish step");

endmodule

[rtl/core/particle_lifetime_update.sv]
// Particle lifetime update: advances one particle by one time tick per input
// beat and returns one result beat per tick. A tick that finds the particle's
// life used up respawns it at the start position and then goes to the finish
// step; any other tick updates the position, waits for the bit-serial fraction
// divider (which runs alongside the position update), then does five
// interpolations and the alpha scaling on the one shared 18x33 multiplier.
// One tick is worked on at a time; the next beat is taken as soon as the result
// sits in the output register. Configuration registers are written through
// cfg_wr_en/cfg_index/cfg_wdata; the user must write them only while idle, as the block itself does not enforce it.
// Depends on plt_pkg, plt_ctrl and plt_dp.
module particle_lifetime_update
    import plt_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_wr_en,
    input  logic [2:0]  cfg_index,
    input  logic [47:0] cfg_wdata,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // time_step
    output logic        m_tvalid,
    input  logic        m_tready,
    // pos_x, pos_y, pos_z, red, green, blue, alpha, particle_size
    output logic [95:0] m_tdata,
    output logic        m_tuser    // respawned
);

    plt_cmd_t    cmd;
    plt_status_t status;

    plt_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .status   (status),
        .cmd      (cmd)
    );

    plt_dp u_dp (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_index     (cfg_index),
        .cfg_wdata     (cfg_wdata),
        .time_step     (s_tdata),
        .cmd           (cmd),
        .status        (status),
        .out_data      (m_tdata),
        .out_respawned (m_tuser)
    );

endmodule
